>>> rtl/core/rmlr_pkg.sv
// Shared types and constants for the recursive midpoint line rasterizer.
// No dependencies; every rmlr module refers to this package by scoped names.
`timescale 1ns / 1ps

package rmlr_pkg;

    localparam int COORD_W     = 6;
    localparam int COORD_MAX   = 63;
    localparam int STACK_DEPTH = 8;
    localparam int MAX_POINTS  = 64;
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int IN_W        = 4 * COORD_W;
    localparam int OUT_W       = 16;

    typedef logic [COORD_W-1:0] coord_t;

    // Packed so that sx sits in the lowest bits, as on the input word.
    typedef struct packed {
        coord_t ey;
        coord_t sy;
        coord_t ex;
        coord_t sx;
    } seg_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/core/rmlr_ctrl.sv
// Sequencer for the midpoint line rasterizer: accepts a segment, then steps
// the datapath once per subdivision node until it reports the last word.
// Depends on rmlr_pkg.
`timescale 1ns / 1ps

module rmlr_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  rmlr_pkg::sts_t  sts,
    output rmlr_pkg::cmd_t  cmd
);

    rmlr_pkg::state_t state_reg;
    rmlr_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmlr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rmlr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = rmlr_pkg::ST_RUN;
                end
            end
            rmlr_pkg::ST_RUN:
            begin
                if (sts.out_free && sts.done)
                begin
                    state_next = rmlr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmlr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            rmlr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            rmlr_pkg::ST_RUN:
            begin
                cmd.step = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    a_step_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> state_reg == rmlr_pkg::ST_RUN)
        else $error("step issued outside RUN");

    a_load_enters_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == rmlr_pkg::ST_RUN)
        else $error("load did not start a run");

    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && sts.done) |=> state_reg == rmlr_pkg::ST_IDLE)
        else $error("final step did not return to IDLE");

endmodule

>>> rtl/core/rmlr_datapath.sv
// Datapath of the midpoint line rasterizer: current segment, stack of
// pending lower halves, point counter and the output word register.
// Depends on rmlr_pkg.
`timescale 1ns / 1ps

module rmlr_datapath
#(
    parameter int STACK_DEPTH = rmlr_pkg::STACK_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rmlr_pkg::IN_W-1:0]     s_tdata,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [rmlr_pkg::OUT_W-1:0]    m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser,
    input  rmlr_pkg::cmd_t                cmd,
    output rmlr_pkg::sts_t                sts
);

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    rmlr_pkg::seg_t               stack_mem [STACK_DEPTH];

    rmlr_pkg::seg_t               cur_reg;
    rmlr_pkg::seg_t               cur_next;
    logic                         err_reg;
    logic                         err_next;
    logic [LVL_W-1:0]             level_reg;
    logic [LVL_W-1:0]             level_next;
    logic [rmlr_pkg::CNT_W-1:0]   count_reg;
    logic [rmlr_pkg::CNT_W-1:0]   count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    rmlr_pkg::coord_t             out_x_reg;
    rmlr_pkg::coord_t             out_x_next;
    rmlr_pkg::coord_t             out_y_reg;
    rmlr_pkg::coord_t             out_y_next;
    logic                         out_last_reg;
    logic                         out_last_next;
    logic                         out_err_reg;
    logic                         out_err_next;

    rmlr_pkg::seg_t               in_seg;
    rmlr_pkg::seg_t               raw_seg;
    rmlr_pkg::seg_t               lower_seg;
    rmlr_pkg::seg_t               upper_seg;
    rmlr_pkg::coord_t             mx;
    rmlr_pkg::coord_t             my;
    logic [LVL_W-1:0]             level_dec;
    logic                         leaf;
    logic                         at_end;
    logic                         push;

    function automatic rmlr_pkg::coord_t clamp(input rmlr_pkg::coord_t v);
        rmlr_pkg::coord_t r;
        r = v;
        if (v > rmlr_pkg::COORD_W'(rmlr_pkg::COORD_MAX))
        begin
            r = rmlr_pkg::COORD_W'(rmlr_pkg::COORD_MAX);
        end
        return r;
    endfunction

    assign raw_seg   = rmlr_pkg::seg_t'(s_tdata);
    assign in_seg.sx = clamp(raw_seg.sx);
    assign in_seg.ex = clamp(raw_seg.ex);
    assign in_seg.sy = clamp(raw_seg.sy);
    assign in_seg.ey = clamp(raw_seg.ey);

    assign mx = rmlr_pkg::COORD_W'(({1'b0, cur_reg.sx} + {1'b0, cur_reg.ex}) >> 1);
    assign my = rmlr_pkg::COORD_W'(({1'b0, cur_reg.sy} + {1'b0, cur_reg.ey}) >> 1);

    assign lower_seg = '{ey: my, sy: cur_reg.sy, ex: mx, sx: cur_reg.sx};
    assign upper_seg = '{ey: cur_reg.ey, sy: my, ex: cur_reg.ex, sx: mx};

    assign leaf      = (cur_reg.sx == mx) && (cur_reg.sy == my);
    assign at_end    = (level_reg == '0) ||
                       (count_reg == rmlr_pkg::CNT_W'(rmlr_pkg::MAX_POINTS - 1));
    assign level_dec = level_reg - 1'b1;
    assign push      = cmd.step && !err_reg && !leaf &&
                       (level_reg < LVL_W'(STACK_DEPTH));

    assign sts.done     = err_reg || (leaf && at_end);
    assign sts.out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        cur_next       = cur_reg;
        err_next       = err_reg;
        level_next     = level_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        if (cmd.load)
        begin
            cur_next   = in_seg;
            err_next   = (in_seg.sx > in_seg.ex) || (in_seg.sy > in_seg.ey);
            level_next = '0;
            count_next = '0;
        end
        else if (cmd.step)
        begin
            if (err_reg)
            begin
                out_valid_next = 1'b1;
                out_x_next     = '0;
                out_y_next     = '0;
                out_last_next  = 1'b1;
                out_err_next   = 1'b1;
            end
            else if (leaf)
            begin
                out_valid_next = 1'b1;
                out_x_next     = mx;
                out_y_next     = my;
                out_last_next  = at_end;
                out_err_next   = 1'b0;
                count_next     = count_reg + 1'b1;
                if (!at_end)
                begin
                    level_next = level_dec;
                    cur_next   = stack_mem[level_dec[IDX_W-1:0]];
                end
            end
            else
            begin
                if (push)
                begin
                    level_next = level_reg + 1'b1;
                end
                cur_next = upper_seg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[level_reg[IDX_W-1:0]] <= lower_seg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            err_reg       <= 1'b0;
            level_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            err_reg       <= err_next;
            level_reg     <= level_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rmlr_pkg::OUT_W - 2 * rmlr_pkg::COORD_W){1'b0}}, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    a_level_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rmlr_pkg::CNT_W'(rmlr_pkg::MAX_POINTS))
        else $error("point count beyond limit");

    a_error_word_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("error word carries a point or is not last");

    a_pop_only_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !err_reg && leaf && !at_end) |-> level_reg != '0)
        else $error("pop from empty stack");

endmodule

>>> rtl/core/recursive_midpoint_line_raster.sv
// Top level of the recursive midpoint line rasterizer.
// Joins rmlr_ctrl and rmlr_datapath; depends on rmlr_pkg.
//
// Usage:
//   The slave channel (s_*) takes one segment word per handshake; the
//   master channel (m_*) returns the plotted points of that segment, from
//   near the end point down to the start point, the end point excluded.
//   m_tlast marks the final word of a segment. A segment whose start lies
//   above its end on either axis returns a single word with m_tuser set,
//   m_tlast set and zero coordinates. Coordinates above COORD_MAX are
//   saturated on entry.
//   Throughput: the segment is loaded, then the datapath takes one
//   subdivision node per cycle while the output register is free, with a
//   single midpoint step per node; an out-of-order segment gives its
//   error word at its first step.
//   s_tready is high only while no segment is in work; the next segment is
//   taken while the final word still waits in the output register.
//   When m_tready is low and a word is held, that word holds and the datapath waits.
//   Reset (rst_n low) empties the output register and returns to idle.
`timescale 1ns / 1ps

module recursive_midpoint_line_raster
#(
    parameter int STACK_DEPTH = rmlr_pkg::STACK_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x[5:0], end_x[11:6], start_y[17:12], end_y[23:18]
    input  logic [rmlr_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // point_x[5:0], point_y[11:6], zero fill [15:12]
    output logic [rmlr_pkg::OUT_W-1:0]    m_tdata,
    output logic                          m_tlast,
    // order_error[0]
    output logic                          m_tuser
);

    rmlr_pkg::cmd_t cmd;
    rmlr_pkg::sts_t sts;

    rmlr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rmlr_datapath
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

>>> dv/raster_output_check.sv
// Output checker for the recursive midpoint line rasterizer: watches both stream channels,
// predicts the plotted points of every accepted segment and compares each output word.
// Depends on rmlr_pkg for the segment layout and the sizes.
`timescale 1ns / 1ps

module raster_output_check
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [rmlr_pkg::IN_W-1:0]     s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rmlr_pkg::OUT_W-1:0]    m_tdata,
    input  logic                          m_tlast,
    input  logic                          m_tuser,
    output int                            mismatch_count,
    output int                            points_due
);

    typedef struct {
        rmlr_pkg::coord_t point_x;
        rmlr_pkg::coord_t point_y;
        logic             last_point;
        logic             order_error;
    } plot_word_t;

    plot_word_t due_points[$];

    initial
    begin
        mismatch_count = 0;
        points_due     = 0;
    end

    // Walk the subdivision with a bounded stack of lower halves, upper half first.
    task automatic plot_segment(input rmlr_pkg::seg_t seg);
        rmlr_pkg::seg_t   lower_halves [rmlr_pkg::STACK_DEPTH];
        rmlr_pkg::seg_t   cur;
        rmlr_pkg::coord_t mid_x;
        rmlr_pkg::coord_t mid_y;
        logic [6:0]       sum_x;
        logic [6:0]       sum_y;
        int               level;
        logic             running;
        plot_word_t       w;
        plot_word_t       pts[$];
        if (seg.sx > seg.ex || seg.sy > seg.ey)
        begin
            w.point_x     = '0;
            w.point_y     = '0;
            w.last_point  = 1'b1;
            w.order_error = 1'b1;
            due_points.push_back(w);
            return;
        end
        cur     = seg;
        level   = 0;
        running = 1'b1;
        while (running)
        begin
            sum_x = {1'b0, cur.sx} + {1'b0, cur.ex};
            sum_y = {1'b0, cur.sy} + {1'b0, cur.ey};
            mid_x = sum_x[6:1];
            mid_y = sum_y[6:1];
            if (cur.sx == mid_x && cur.sy == mid_y)
            begin
                if (pts.size() < rmlr_pkg::MAX_POINTS)
                begin
                    w.point_x     = mid_x;
                    w.point_y     = mid_y;
                    w.last_point  = 1'b0;
                    w.order_error = 1'b0;
                    pts.push_back(w);
                end
                if (level == 0 || pts.size() >= rmlr_pkg::MAX_POINTS)
                    running = 1'b0;
                else
                begin
                    level--;
                    cur = lower_halves[level];
                end
            end
            else
            begin
                if (level < rmlr_pkg::STACK_DEPTH)
                begin
                    lower_halves[level] = {mid_y, cur.sy, mid_x, cur.sx};
                    level++;
                end
                cur = {cur.ey, mid_y, cur.ex, mid_x};
            end
        end
        w = pts.pop_back();
        w.last_point = 1'b1;
        pts.push_back(w);
        foreach (pts[i])
            due_points.push_back(pts[i]);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        plot_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_points.size() == 0)
                begin
                    $error("unexpected output word: point_x %0d point_y %0d last %0b err %0b",
                           m_tdata[5:0], m_tdata[11:6], m_tlast, m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = due_points.pop_front();
                    compare_field("point_x", int'(want.point_x), int'(m_tdata[5:0]));
                    compare_field("point_y", int'(want.point_y), int'(m_tdata[11:6]));
                    compare_field("last_point", int'(want.last_point), int'(m_tlast));
                    compare_field("order_error", int'(want.order_error), int'(m_tuser));
                end
            end
            if (s_tvalid && s_tready)
                plot_segment(rmlr_pkg::seg_t'(s_tdata));
            points_due = due_points.size();
        end
    end

endmodule

>>> dv/recursive_midpoint_line_raster_tb.sv
// Testbench top for the recursive midpoint line rasterizer: drives segments and
// output back-pressure, and gives the verdict from raster_output_check.
// Depends on rmlr_pkg, recursive_midpoint_line_raster and raster_output_check.
`timescale 1ns / 1ps

module recursive_midpoint_line_raster_tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 200;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 46;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic [rmlr_pkg::IN_W-1:0]     s_tdata  = '0;
    logic                          m_tready = 1'b0;
    logic                          s_tready;
    logic                          m_tvalid;
    logic [rmlr_pkg::OUT_W-1:0]    m_tdata;
    logic                          m_tlast;
    logic                          m_tuser;
    int                            mismatch_count;
    int                            points_due;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    always #5 clk = ~clk;

    recursive_midpoint_line_raster DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    raster_output_check u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .points_due     (points_due)
    );

    // Hold off the output for a long stretch on request, else stall at random.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_taken != hold_requests)
        begin
            hold_taken = hold_requests;
            hold_left  = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_segment(input rmlr_pkg::coord_t sx, input rmlr_pkg::coord_t ex,
                                input rmlr_pkg::coord_t sy, input rmlr_pkg::coord_t ey);
        rmlr_pkg::seg_t seg;
        seg = {ey, sy, ex, sx};
        s_tvalid <= 1'b1;
        s_tdata  <= seg;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= rmlr_pkg::IN_W'($urandom);
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    // Mostly well-ordered segments, short and long; some with start above end.
    task automatic send_random_segment();
        int a;
        int b;
        int c;
        int d;
        int kind;
        kind = $urandom_range(99);
        a = $urandom_range(63);
        c = $urandom_range(63);
        if (kind < 45)
        begin
            b = a + $urandom_range(7);
            d = c + $urandom_range(7);
            if (b > 63) b = 63;
            if (d > 63) d = 63;
        end
        else if (kind < 85)
        begin
            b = $urandom_range(a, 63);
            d = $urandom_range(c, 63);
        end
        else
        begin
            b = $urandom_range(62);
            a = $urandom_range(b + 1, 63);
            d = $urandom_range(63);
            if ($urandom_range(1))
            begin
                send_segment(rmlr_pkg::COORD_W'(c), rmlr_pkg::COORD_W'(d),
                             rmlr_pkg::COORD_W'(a), rmlr_pkg::COORD_W'(b));
                return;
            end
        end
        send_segment(rmlr_pkg::COORD_W'(a), rmlr_pkg::COORD_W'(b),
                     rmlr_pkg::COORD_W'(c), rmlr_pkg::COORD_W'(d));
    endtask

    task automatic drain_points();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (points_due == 0);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_segment(0, 0, 0, 0);
        send_segment(63, 63, 63, 63);
        send_segment(0, 63, 0, 63);
        send_segment(0, 63, 0, 0);
        send_segment(0, 0, 0, 63);
        send_segment(0, 63, 63, 63);
        send_segment(0, 1, 0, 63);
        send_segment(5, 6, 7, 8);
        send_segment(10, 11, 20, 20);
        send_segment(62, 63, 62, 63);
        send_segment(63, 0, 0, 0);
        send_segment(0, 0, 63, 0);
        send_segment(40, 39, 40, 39);
        send_segment(21, 42, 42, 63);
        send_segment(42, 63, 21, 42);
        drain_points();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            repeat (PHASE_ITEMS)
                send_random_segment();
            drain_points();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        repeat (10)
            send_random_segment();
        drain_points();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
